// ===== src/hisim_pkg.sv =====
// Shared widths, constants and the accumulated-sums record for the
// histogram intersection block. No dependencies.
package hisim_pkg;

  localparam int BIN_BITS   = 16;
  localparam int COUNT_BITS = 16;
  localparam int ACC_BITS   = 26;
  localparam int FRAC_BITS  = 16;
  localparam int Q_BITS     = FRAC_BITS + 1;
  localparam int DIV_STEPS  = Q_BITS;
  localparam int STEP_BITS  = $clog2(DIV_STEPS + 1);

  localparam int QUEUE_DEPTH = 2;
  localparam int PTR_BITS    = $clog2(QUEUE_DEPTH);
  localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);

  // Counts are taken in their low COUNT_BITS bits.
  localparam logic [BIN_BITS-1:0] COUNT_MASK =
    (COUNT_BITS >= BIN_BITS) ? {BIN_BITS{1'b1}} :
                               BIN_BITS'((64'd1 << COUNT_BITS) - 64'd1);

  localparam logic [ACC_BITS-1:0] ACC_MAX = {ACC_BITS{1'b1}};

  typedef struct packed {
    logic [ACC_BITS-1:0] min_sum;
    logic [ACC_BITS-1:0] ref_sum;
    logic                overflow;
  } hisim_sums_t;

endpackage

// ===== src/hisim_front.sv =====
// Front end: takes bin beats, keeps saturating sums of min(a,b) and a,
// and hands the finished sums of a histogram pair to the queue. Uses hisim_pkg.
module hisim_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          bin_valid,
  output logic                          bin_stall,
  input  logic [hisim_pkg::BIN_BITS-1:0] bin_a,
  input  logic [hisim_pkg::BIN_BITS-1:0] bin_b,
  input  logic                          last_bin,
  input  logic                          queue_full,
  output logic                          push,
  output hisim_pkg::hisim_sums_t        push_data
);
  import hisim_pkg::*;

  logic [ACC_BITS-1:0] min_sum, min_sum_next;
  logic [ACC_BITS-1:0] ref_sum, ref_sum_next;
  logic                overflow_seen, overflow_next;
  logic [BIN_BITS-1:0] a, b, m;
  logic [ACC_BITS:0]   min_add, ref_add;
  logic                accept;

  assign bin_stall = queue_full;
  assign accept    = bin_valid && !queue_full;

  always_comb begin
    a = bin_a & COUNT_MASK;
    b = bin_b & COUNT_MASK;
    m = (a < b) ? a : b;
    min_add = {1'b0, min_sum} + (ACC_BITS + 1)'(m);
    ref_add = {1'b0, ref_sum} + (ACC_BITS + 1)'(a);
    min_sum_next  = min_add[ACC_BITS] ? ACC_MAX : min_add[ACC_BITS-1:0];
    ref_sum_next  = ref_add[ACC_BITS] ? ACC_MAX : ref_add[ACC_BITS-1:0];
    overflow_next = overflow_seen || min_add[ACC_BITS] || ref_add[ACC_BITS];
  end

  assign push              = accept && last_bin;
  assign push_data.min_sum = min_sum_next;
  assign push_data.ref_sum = ref_sum_next;
  assign push_data.overflow = overflow_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_sum       <= '0;
      ref_sum       <= '0;
      overflow_seen <= 1'b0;
    end else if (accept) begin
      if (last_bin) begin
        min_sum       <= '0;
        ref_sum       <= '0;
        overflow_seen <= 1'b0;
      end else begin
        min_sum       <= min_sum_next;
        ref_sum       <= ref_sum_next;
        overflow_seen <= overflow_next;
      end
    end
  end

endmodule

// ===== src/hisim_queue.sv =====
// Short queue of finished histogram-pair sums between front and back.
// Uses hisim_pkg.
module hisim_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  hisim_pkg::hisim_sums_t push_data,
  output logic                   full,
  output logic                   not_empty,
  input  logic                   pop,
  output hisim_pkg::hisim_sums_t pop_data
);
  import hisim_pkg::*;

  hisim_sums_t         entries [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr, rd_ptr;
  logic [CNT_BITS-1:0] count;

  assign full      = (count == CNT_BITS'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign pop_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== src/hisim_back.sv =====
// Back end: restoring divider producing floor(min_sum * 2^16 / ref_sum),
// one quotient bit per cycle, then the result output register. Uses hisim_pkg.
module hisim_back (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           queue_not_empty,
  output logic                           pop,
  input  hisim_pkg::hisim_sums_t         pop_data,
  output logic                           result_valid,
  input  logic                           result_stall,
  output logic [hisim_pkg::Q_BITS-1:0]   similarity,
  output logic                           empty_reference,
  output logic                           sum_saturated
);
  import hisim_pkg::*;

  typedef enum logic [1:0] {IDLE, RUN, DONE} state_t;

  state_t               state;
  logic [STEP_BITS-1:0] step;
  logic [ACC_BITS-1:0]  rem, rem_next;
  logic [ACC_BITS-1:0]  divisor;
  logic [Q_BITS-1:0]    quo;
  logic                 empty, sat;
  logic [ACC_BITS:0]    cur, diff;
  logic                 ge, out_free;

  assign pop      = (state == IDLE) && queue_not_empty;
  assign out_free = !result_valid || !result_stall;

  // First step compares min_sum itself (integer bit); later steps shift in zeros.
  always_comb begin
    cur      = (step == STEP_BITS'(DIV_STEPS)) ? {1'b0, rem} : {rem, 1'b0};
    diff     = cur - {1'b0, divisor};
    ge       = (cur >= {1'b0, divisor});
    rem_next = ge ? diff[ACC_BITS-1:0] : cur[ACC_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= IDLE;
      result_valid <= 1'b0;
    end else begin
      if (state == DONE && out_free) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (queue_not_empty) begin
            rem     <= pop_data.min_sum;
            divisor <= pop_data.ref_sum;
            empty   <= (pop_data.ref_sum == '0);
            sat     <= pop_data.overflow;
            step    <= STEP_BITS'(DIV_STEPS);
            state   <= RUN;
          end
        end
        RUN: begin
          rem  <= rem_next;
          quo  <= {quo[Q_BITS-2:0], ge};
          step <= step - 1'b1;
          if (step == STEP_BITS'(1)) begin
            state <= DONE;
          end
        end
        DONE: begin
          if (out_free) begin
            similarity      <= empty ? '0 : quo;
            empty_reference <= empty;
            sum_saturated   <= sat;
            state           <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

// ===== src/histogram_intersection_similarity.sv =====
// Top level of the histogram intersection block: front accumulator, sums
// queue and divider back end. Uses hisim_pkg, hisim_front, hisim_queue, hisim_back.
//
// Usage: bins of histograms A and B arrive as one beat per bin on the bin
// channel (bin_valid / bin_stall; bin_a, bin_b, last_bin). The beat with
// last_bin set closes the pair; the result channel (result_valid /
// result_stall) then carries similarity = sum(min(a,b)) / sum(a) in unsigned
// Q1.16, empty_reference when sum(a) is zero (similarity 0) and
// sum_saturated when a 26-bit sum clipped during the pair.
// Throughput: one bin per cycle while the sums queue is not full. The divider
// makes one quotient bit per cycle plus hand-off per pair, so pairs whose bins
// arrive faster than it finishes them are limited by the divider; a two-entry
// queue of finished sums sits between accumulator and divider. After the last
// bin is accepted, its sums pass through the queue, the divider's IDLE load,
// RUN steps and DONE state into the result register before result_valid rises.
// bin_stall is high only while the sums queue is full. A stalled result is
// held; the divider finishes the next pair and waits behind it.
// Reset (rst, synchronous) clears the sums, the queue and result_valid.
module histogram_intersection_similarity (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           bin_valid,
  output logic                           bin_stall,
  input  logic [hisim_pkg::BIN_BITS-1:0] bin_a,
  input  logic [hisim_pkg::BIN_BITS-1:0] bin_b,
  input  logic                           last_bin,
  output logic                           result_valid,
  input  logic                           result_stall,
  output logic [hisim_pkg::Q_BITS-1:0]   similarity,
  output logic                           empty_reference,
  output logic                           sum_saturated
);
  import hisim_pkg::*;

  logic        push, pop, queue_full, queue_not_empty;
  hisim_sums_t push_data, pop_data;

  hisim_front u_front (
    .clk        (clk),
    .rst        (rst),
    .bin_valid  (bin_valid),
    .bin_stall  (bin_stall),
    .bin_a      (bin_a),
    .bin_b      (bin_b),
    .last_bin   (last_bin),
    .queue_full (queue_full),
    .push       (push),
    .push_data  (push_data)
  );

  hisim_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (queue_full),
    .not_empty (queue_not_empty),
    .pop       (pop),
    .pop_data  (pop_data)
  );

  hisim_back u_back (
    .clk             (clk),
    .rst             (rst),
    .queue_not_empty (queue_not_empty),
    .pop             (pop),
    .pop_data        (pop_data),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .similarity      (similarity),
    .empty_reference (empty_reference),
    .sum_saturated   (sum_saturated)
  );

endmodule

// ===== src/hisim_checker.sv =====
// Port-level checks for histogram_intersection_similarity, bound to the top
// level. Uses hisim_pkg for widths.
module hisim_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           bin_valid,
  input logic                           bin_stall,
  input logic                           result_valid,
  input logic                           result_stall,
  input logic [hisim_pkg::Q_BITS-1:0]   similarity,
  input logic                           empty_reference,
  input logic                           sum_saturated
);
  import hisim_pkg::*;

  // A held result beat keeps its payload.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(similarity)
      && $stable(empty_reference) && $stable(sum_saturated))
    else $error("result beat changed while stalled");

  assert property (@(posedge clk) $past(rst) |-> !result_valid)
    else $error("result_valid set right after reset");

  // Ratio never exceeds 1.0.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && similarity[Q_BITS-1] |-> similarity[Q_BITS-2:0] == '0)
    else $error("similarity above 1.0");

  assert property (@(posedge clk) disable iff (rst)
    result_valid && empty_reference |-> similarity == '0 && !sum_saturated)
    else $error("empty reference with nonzero similarity or saturation");

  // The input stall rises only after an accepted bin beat fills the sums queue.
  assert property (@(posedge clk) disable iff (rst)
    $rose(bin_stall) |-> !$past(bin_stall) && $past(bin_valid))
    else $error("input stall raised without a bin beat");

endmodule

bind histogram_intersection_similarity hisim_checker u_hisim_checker (
  .clk             (clk),
  .rst             (rst),
  .bin_valid       (bin_valid),
  .bin_stall       (bin_stall),
  .result_valid    (result_valid),
  .result_stall    (result_stall),
  .similarity      (similarity),
  .empty_reference (empty_reference),
  .sum_saturated   (sum_saturated)
);

// ===== dv/histogram_intersection_similarity_checker.sv =====
`timescale 1ns / 100ps
// Checker for the histogram intersection block: watches the bin and result channels,
// predicts the similarity of each pair and compares it beat by beat. Uses hisim_pkg.
module histogram_intersection_similarity_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           bin_valid,
  input  logic                           bin_stall,
  input  logic [hisim_pkg::BIN_BITS-1:0] bin_a,
  input  logic [hisim_pkg::BIN_BITS-1:0] bin_b,
  input  logic                           last_bin,
  input  logic                           result_valid,
  input  logic                           result_stall,
  input  logic [hisim_pkg::Q_BITS-1:0]   similarity,
  input  logic                           empty_reference,
  input  logic                           sum_saturated,
  output int                             fail_count,
  output int                             pairs_pending
);
  import hisim_pkg::*;

  typedef struct packed {
    logic [Q_BITS-1:0] ratio;
    logic              empty;
    logic              clipped;
  } ratio_beat_t;

  localparam logic [63:0] Q_ONE = 64'd1 << FRAC_BITS;

  logic [ACC_BITS-1:0] pair_min_sum;
  logic [ACC_BITS-1:0] pair_ref_sum;
  logic                pair_clipped;
  ratio_beat_t         ratio_q[$];

  always @(posedge clk) begin : track
    logic [BIN_BITS-1:0] a_cnt, b_cnt, lo_cnt;
    logic [ACC_BITS:0]   min_wide, ref_wide;
    logic [63:0]         quot;
    ratio_beat_t         want;
    if (rst) begin
      pair_min_sum = '0;
      pair_ref_sum = '0;
      pair_clipped = 1'b0;
      ratio_q.delete();
      fail_count = 0;
    end else begin
      if (result_valid && !result_stall) begin
        if (ratio_q.size() == 0) begin
          fail_count++;
          $error("result beat with no pair pending: similarity %0d", similarity);
        end else begin
          want = ratio_q.pop_front();
          if (similarity !== want.ratio) begin
            fail_count++;
            $error("similarity: expected %0d, got %0d", want.ratio, similarity);
          end
          if (empty_reference !== want.empty) begin
            fail_count++;
            $error("empty_reference: expected %0b, got %0b", want.empty, empty_reference);
          end
          if (sum_saturated !== want.clipped) begin
            fail_count++;
            $error("sum_saturated: expected %0b, got %0b", want.clipped, sum_saturated);
          end
        end
      end
      if (bin_valid && !bin_stall) begin
        a_cnt  = bin_a & COUNT_MASK;
        b_cnt  = bin_b & COUNT_MASK;
        lo_cnt = (a_cnt < b_cnt) ? a_cnt : b_cnt;
        min_wide = {1'b0, pair_min_sum} + lo_cnt;
        ref_wide = {1'b0, pair_ref_sum} + a_cnt;
        // both sums clip at full scale and latch the flag for the pair
        if (min_wide[ACC_BITS]) begin
          pair_min_sum = ACC_MAX;
          pair_clipped = 1'b1;
        end else begin
          pair_min_sum = min_wide[ACC_BITS-1:0];
        end
        if (ref_wide[ACC_BITS]) begin
          pair_ref_sum = ACC_MAX;
          pair_clipped = 1'b1;
        end else begin
          pair_ref_sum = ref_wide[ACC_BITS-1:0];
        end
        if (last_bin) begin
          want.empty = (pair_ref_sum == '0);
          quot = '0;
          if (!want.empty) begin
            quot = (64'(pair_min_sum) << FRAC_BITS) / 64'(pair_ref_sum);
            if (quot > Q_ONE) quot = Q_ONE;
          end
          want.ratio   = quot[Q_BITS-1:0];
          want.clipped = pair_clipped;
          ratio_q.push_back(want);
          pair_min_sum = '0;
          pair_ref_sum = '0;
          pair_clipped = 1'b0;
        end
      end
    end
    pairs_pending = ratio_q.size();
  end

endmodule

// ===== dv/histogram_intersection_similarity_tb.sv =====
`timescale 1ns / 100ps
// Testbench top for histogram_intersection_similarity: clock, reset, bin stimulus and
// result back-pressure. Depends on hisim_pkg, the block and the checker module.
module histogram_intersection_similarity_tb;
  import hisim_pkg::*;

  localparam int BIN_TOTAL    = 1700;
  localparam int CALM_BINS    = 200;
  localparam int LONG_PAIR    = 1030;
  localparam int DRAIN_CYCLES = 40;

  logic                clk;
  logic                rst;
  logic                bin_valid;
  logic                bin_stall;
  logic [BIN_BITS-1:0] bin_a;
  logic [BIN_BITS-1:0] bin_b;
  logic                last_bin;
  logic                result_valid;
  logic                result_stall;
  logic [Q_BITS-1:0]   similarity;
  logic                empty_reference;
  logic                sum_saturated;

  logic calm;
  logic sender_gappy;
  int   bins_sent;
  int   fail_count;
  int   pairs_pending;

  histogram_intersection_similarity dut (
    .clk             (clk),
    .rst             (rst),
    .bin_valid       (bin_valid),
    .bin_stall       (bin_stall),
    .bin_a           (bin_a),
    .bin_b           (bin_b),
    .last_bin        (last_bin),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .similarity      (similarity),
    .empty_reference (empty_reference),
    .sum_saturated   (sum_saturated)
  );

  histogram_intersection_similarity_checker ratio_check (
    .clk             (clk),
    .rst             (rst),
    .bin_valid       (bin_valid),
    .bin_stall       (bin_stall),
    .bin_a           (bin_a),
    .bin_b           (bin_b),
    .last_bin        (last_bin),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .similarity      (similarity),
    .empty_reference (empty_reference),
    .sum_saturated   (sum_saturated),
    .fail_count      (fail_count),
    .pairs_pending   (pairs_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_bin(input logic [BIN_BITS-1:0] a, input logic [BIN_BITS-1:0] b,
                          input logic last);
    if ($urandom_range(0, 39) == 0) sender_gappy = ~sender_gappy;
    if (!calm && sender_gappy && $urandom_range(0, 2) == 0) begin
      bin_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    bin_valid <= 1'b1;
    bin_a     <= a;
    bin_b     <= b;
    last_bin  <= last;
    do @(posedge clk); while (bin_stall);
    @(negedge clk);
    bins_sent++;
  endtask

  function automatic logic [BIN_BITS-1:0] pick_count();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return BIN_BITS'($urandom_range(0, 15));
      default: return BIN_BITS'($urandom);
    endcase
  endfunction

  task automatic send_pair(input int len);
    logic [BIN_BITS-1:0] a, b;
    logic                empty_a;
    empty_a = ($urandom_range(0, 15) == 0);
    for (int i = 0; i < len; i++) begin
      a = empty_a ? '0 : pick_count();
      case ($urandom_range(0, 3))
        0:       b = a;
        1:       b = a + BIN_BITS'($urandom_range(0, 3));
        default: b = pick_count();
      endcase
      send_bin(a, b, i == len - 1);
    end
  endtask

  // result back-pressure: bursty stretches alternate with quiet ones
  initial begin
    logic gappy;
    result_stall = 1'b0;
    gappy = 1'b0;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 63) == 0) gappy = ~gappy;
      if (!calm && gappy && $urandom_range(0, 3) == 0) begin
        result_stall <= 1'b1;
        repeat ($urandom_range(1, 15)) @(negedge clk);
      end
      result_stall <= 1'b0;
    end
  end

  initial begin
    logic long_done;
    rst          = 1'b1;
    bin_valid    = 1'b0;
    bin_a        = '0;
    bin_b        = '0;
    last_bin     = 1'b0;
    calm         = 1'b0;
    sender_gappy = 1'b1;
    bins_sent    = 0;
    long_done    = 1'b0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // empty reference, exact 1.0, zero overlap
    send_bin('0, '0, 1'b1);
    send_bin('1, '1, 1'b1);
    send_bin('1, '0, 1'b1);
    send_bin('0, '1, 1'b1);
    // truncation with a large denominator
    send_bin(16'd1, '1, 1'b0);
    send_bin('1, 16'd1, 1'b0);
    send_bin(16'd2, 16'd3, 1'b1);
    // B nonzero while A stays empty over two bins
    send_bin('0, 16'd5, 1'b0);
    send_bin('0, 16'd7, 1'b1);
    send_bin(16'd3, 16'd2, 1'b0);
    send_bin(16'd7, 16'd7, 1'b1);
    send_bin(16'haaaa, 16'h5555, 1'b0);
    send_bin(16'h5555, 16'haaaa, 1'b1);

    while (bins_sent < BIN_TOTAL) begin
      if (bins_sent >= BIN_TOTAL - CALM_BINS) calm <= 1'b1;
      if (!long_done && bins_sent >= 300) begin
        // full-scale A over LONG_PAIR bins clips the 26-bit reference sum
        for (int i = 0; i < LONG_PAIR; i++)
          send_bin('1, $urandom_range(0, 1) ? '1 : pick_count(), i == LONG_PAIR - 1);
        long_done = 1'b1;
      end else if ($urandom_range(0, 7) == 0) begin
        send_pair($urandom_range(17, 64));
      end else begin
        send_pair($urandom_range(1, 16));
      end
    end
    bin_valid <= 1'b0;

    while (pairs_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0 && pairs_pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/hisim_pkg.sv
src/hisim_front.sv
src/hisim_queue.sv
src/hisim_back.sv
src/histogram_intersection_similarity.sv
src/hisim_checker.sv
dv/histogram_intersection_similarity_checker.sv
dv/histogram_intersection_similarity_tb.sv
